// ===== sv/csf_pkg.sv =====
// Shared constants and types for the cross stencil smoothing filter.
// Image geometry, line-buffer entry layout, result beat and flush control structs.
// No dependencies.
package csf_pkg;

   localparam int IMG_WIDTH  = 32;
   localparam int IMG_HEIGHT = 32;

   localparam int PIX_W = 8;
   localparam int COL_W = $clog2(IMG_WIDTH);
   localparam int ROW_W = $clog2(IMG_HEIGHT);
   // line buffer entry: [15:8] pixel two rows up, [7:0] pixel one row up
   localparam int ENT_W = 2 * PIX_W;
   localparam int SUM_W = PIX_W + 3;

   localparam logic [COL_W-1:0] COL_LAST = COL_W'(IMG_WIDTH - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(IMG_HEIGHT - 1);

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             run_last;
      logic             frame_last;
   } rsp_type;

   typedef struct packed {
      logic             busy;
      logic             rd_en;
      logic [COL_W-1:0] rd_addr;
      logic             load;
      rsp_type          rsp;
   } flush_ctl_type;

endpackage

// ===== sv/csf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used as the line buffer of the smoothing filter. No dependencies.
module csf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/csf_flush.sv =====
// Frame-end flush sequencer: replays the last image row from the line buffer.
// Depends on csf_pkg; drives the line buffer read port on start and while busy.
module csf_flush import csf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [PIX_W-1:0] last_pix,
   input  logic             out_free,
   input  logic [PIX_W-1:0] rd_pix,
   output flush_ctl_type    ctl
);

   localparam logic [1:0] FL_IDLE = 2'd0;
   localparam logic [1:0] FL_READ = 2'd1;
   localparam logic [1:0] FL_LAST = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [COL_W-1:0] idx_ff, idx_in;
   logic [PIX_W-1:0] pix_ff, pix_in;

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      pix_in          = pix_ff;
      ctl.busy        = (state_ff != FL_IDLE);
      ctl.rd_en       = 1'b0;
      ctl.rd_addr     = '0;
      ctl.load        = 1'b0;
      ctl.rsp.pixel      = rd_pix;
      ctl.rsp.run_last   = 1'b0;
      ctl.rsp.frame_last = 1'b0;
      unique case (state_ff)
         FL_IDLE: begin
            if (start) begin
               ctl.rd_en   = 1'b1;
               ctl.rd_addr = '0;
               idx_in      = '0;
               pix_in      = last_pix;
               state_in    = FL_READ;
            end
         end
         FL_READ: begin
            if (out_free) begin
               ctl.load = 1'b1;
               if (idx_ff == COL_LAST - COL_W'(1)) begin
                  state_in = FL_LAST;
               end else begin
                  ctl.rd_en   = 1'b1;
                  ctl.rd_addr = idx_ff + COL_W'(1);
                  idx_in      = idx_ff + COL_W'(1);
               end
            end
         end
         FL_LAST: begin
            if (out_free) begin
               ctl.load           = 1'b1;
               ctl.rsp.pixel      = pix_ff;
               ctl.rsp.run_last   = 1'b1;
               ctl.rsp.frame_last = 1'b1;
               state_in           = FL_IDLE;
            end
         end
         default: begin
            state_in = FL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FL_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff <= idx_in;
      pix_ff <= pix_in;
   end

endmodule

// ===== sv/cross_stencil_smoothing_filter_unit.sv =====
// Top level of the cross stencil smoothing filter: position counters, stencil stage,
// line buffer and output register. Depends on csf_pkg, csf_ram and csf_flush.
//
//   channel | ports   | beat payload
//   --------+---------+--------------------------------------------------------
//   input   | req_*   | tdata[7:0] pixel_in
//   result  | rsp_*   | tdata[7:0] pixel_out, tlast run_last, tuser[0] frame_last
//
// One pixel per cycle while no result stalls and no flush runs; a result leaves one row behind its input pixel.
// The line buffer RAM (one read, one write port) sets the rate: one read per beat.
// The final pixel of a frame is followed by IMG_WIDTH flush beats from the buffer;
// no input is taken from the final pixel's stencil cycle on until the flush is done.
// Synchronous reset clears position and valid state; buffer contents start unknown.
// A stalled result beat holds in the output register; the stencil stage waits behind it unless its row is 0.
module cross_stencil_smoothing_filter_unit import csf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] pixel_in
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] pixel_out
   output logic       rsp_tlast,   // run_last
   output logic [0:0] rsp_tuser    // [0] frame_last
);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic             s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [ENT_W-1:0] cur_ff;       // entry of the current column
   logic [PIX_W-1:0] left_ff;      // upper-row pixel of the previous column

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept, out_free, s1_emit, s1_final, s1_fire, border;
   logic [COL_W-1:0] next_col;
   logic [ENT_W-1:0] rd_data;
   logic             rd_en;
   logic [COL_W-1:0] rd_addr;
   logic [SUM_W-1:0] sum;
   logic [PIX_W-1:0] smoothed;
   flush_ctl_type    fl;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s1_emit  = (s1_row_ff != '0);
   assign s1_final = (s1_row_ff == ROW_LAST) && (s1_col_ff == COL_LAST);
   assign s1_fire  = s1_valid_ff && (!s1_emit || out_free);

   // hold input while the frame-end flush owns the read port
   assign req_tready = !fl.busy && (!s1_valid_ff || (s1_fire && !s1_final));
   assign accept     = req_tvalid && req_tready;

   assign next_col = (col_ff == COL_LAST) ? '0 : col_ff + COL_W'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         col_in = next_col;
         if (col_ff == COL_LAST) begin
            row_in = (row_ff == ROW_LAST) ? '0 : row_ff + ROW_W'(1);
         end
      end
   end

   // prefetch the entry of the next column so the right neighbor is at hand
   assign rd_en   = accept || fl.rd_en;
   assign rd_addr = fl.rd_en ? fl.rd_addr : next_col;

   csf_ram #(
      .WIDTH (ENT_W),
      .DEPTH (IMG_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_col_ff),
      .wr_data ({cur_ff[PIX_W-1:0], s1_pix_ff}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   csf_flush u_flush (
      .clock    (clock),
      .reset    (reset),
      .start    (s1_fire && s1_final),
      .last_pix (s1_pix_ff),
      .out_free (out_free),
      .rd_pix   (rd_data[PIX_W-1:0]),
      .ctl      (fl)
   );

   assign border = (s1_row_ff == ROW_W'(1)) ||
                   (s1_col_ff == '0) || (s1_col_ff == COL_LAST);

   assign sum = {1'b0, cur_ff[PIX_W-1:0], 2'b00}
              + SUM_W'(cur_ff[ENT_W-1:PIX_W])
              + SUM_W'(s1_pix_ff)
              + SUM_W'(left_ff)
              + SUM_W'(rd_data[PIX_W-1:0]);

   assign smoothed = border ? cur_ff[PIX_W-1:0] : sum[SUM_W-1:3];

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (s1_fire && s1_emit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.pixel       = smoothed;
         rsp_in.run_last    = !s1_final;
         rsp_in.frame_last  = 1'b0;
      end else if (fl.load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = fl.rsp;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         s1_pix_ff <= req_tdata[PIX_W-1:0];
         s1_col_ff <= col_ff;
         s1_row_ff <= row_ff;
      end
      // advance the column window
      if (s1_fire) begin
         cur_ff  <= rd_data;
         left_ff <= cur_ff[PIX_W-1:0];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_ff.pixel;
   assign rsp_tlast    = rsp_ff.run_last;
   assign rsp_tuser[0] = rsp_ff.frame_last;

endmodule
